@@ rtl/core/mob_pkg.sv @@
package mob_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PIN_W    = 16;
    localparam int PIN_EXT_W = (CHANNELS > PIN_W) ? CHANNELS : PIN_W;

    typedef enum logic [3:0] {
        CMD_TICK    = 4'd0,
        CMD_ALLOC   = 4'd1,
        CMD_HIGH    = 4'd2,
        CMD_LOW     = 4'd3,
        CMD_TOGGLE  = 4'd4,
        CMD_ON      = 4'd5,
        CMD_OFF     = 4'd6,
        CMD_RD_LVL  = 4'd7,
        CMD_RD_ACT  = 4'd8,
        CMD_BLINK   = 4'd9,
        CMD_BLINK_N = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_BAD_CHANNEL   = 2'd1,
        STATUS_NOT_ALLOCATED = 2'd2,
        STATUS_NO_FREE       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_STEADY  = 2'd0,
        MODE_BLINK   = 2'd1,
        MODE_BLINK_N = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR
    } state_t;

    // per-channel blink record held in the channel memory
    typedef struct packed {
        logic [15:0] on_dur;
        logic [15:0] off_dur;
        logic [31:0] deadline;
        logic [15:0] done_cnt;
        logic [15:0] wanted_cnt;
    } chan_rec_t;

    localparam int REC_W = $bits(chan_rec_t);

    typedef struct packed {
        logic      due;
        logic      pin;
        mode_t     mode;
        chan_rec_t rec;
    } serve_t;

endpackage

@@ rtl/core/mob_serve.sv @@
module mob_serve (
    input  mob_pkg::chan_rec_t rec,
    input  logic [31:0]        now_ms,
    input  logic               allocated,
    input  logic               active_low,
    input  logic               pin,
    input  mob_pkg::mode_t     mode,
    output mob_pkg::serve_t    result
);
    import mob_pkg::*;

    logic [31:0] since;
    logic [15:0] done_inc;

    assign since    = now_ms - rec.deadline;
    assign done_inc = rec.done_cnt + 16'd1;

    always_comb
    begin
        result      = '0;
        result.rec  = rec;
        result.pin  = pin;
        result.mode = mode;
        result.due  = allocated && (mode != MODE_STEADY) && !since[31];
        if (pin ^ active_low)
        begin
            result.rec.deadline = now_ms + 32'(rec.off_dur);
            if (mode == MODE_BLINK_N)
            begin
                result.rec.done_cnt = done_inc;
                if (done_inc >= rec.wanted_cnt)
                begin
                    result.mode = MODE_STEADY;
                end
            end
        end
        else
        begin
            result.rec.deadline = now_ms + 32'(rec.on_dur);
        end
        result.pin = ~pin;
    end

endmodule

@@ rtl/core/multichannel_output_blinker.sv @@
// multichannel output blinker
// command channel: a transfer happens at a clock edge with start high and busy low;
// cmd, channel, polarity, on_ms, off_ms and blink_count are sampled at that edge.
// result channel: done is high for exactly one cycle and carries status,
// assigned_channel, level and pin_levels; the receiver cannot stall, so the
// result is simply presented for that cycle.
// configuration: cfg_wdata is written into channels_in_use at an edge with cfg_we high.
// latency and throughput: every command except tick gives its result in the cycle
// after the transfer and busy stays low, so one command per cycle is taken.
// a tick walks the managed channels through the blink record memory, a read state
// then a write-back state per channel; busy stays high for the walk, and the result
// comes in the cycle after it. a tick with no managed channels is answered as the
// other commands are, with busy staying low.
// reset: all channels free, active high, steady, pins low, millisecond counter
// zero, channels_in_use 16; the record memory is not cleared and needs no pass.
module multichannel_output_blinker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic [3:0]  cmd,
    input  logic [3:0]  channel,
    input  logic        polarity,
    input  logic [15:0] on_ms,
    input  logic [15:0] off_ms,
    input  logic [15:0] blink_count,
    output logic        done,
    output logic [1:0]  status,
    output logic [3:0]  assigned_channel,
    output logic        level,
    output logic [15:0] pin_levels
);
    import mob_pkg::*;

    state_t              state_reg, state_next;
    logic [4:0]          cfg_reg;
    logic [31:0]         now_reg, now_next;
    logic [CH_W-1:0]     idx_reg, idx_next;
    logic [CHANNELS-1:0] alloc_reg, alloc_next;
    logic [CHANNELS-1:0] al_reg, al_next;
    logic [CHANNELS-1:0] pin_reg, pin_next;
    mode_t               mode_reg [CHANNELS];
    mode_t               mode_next [CHANNELS];
    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [3:0]          assigned_reg, assigned_next;
    logic                level_reg, level_next;

    chan_rec_t           mem [CHANNELS];
    chan_rec_t           rd_reg;
    logic                mem_we, mem_re;
    logic [CH_W-1:0]     mem_waddr;
    chan_rec_t           mem_wdata;

    logic [7:0]          n8;
    logic [7:0]          ch8;
    logic [CH_W-1:0]     chi;
    logic                accept;
    logic                last;
    logic [PIN_EXT_W-1:0] pin_ext;
    serve_t              srv;

    assign n8     = (8'(cfg_reg) > 8'(CHANNELS)) ? 8'(CHANNELS) : 8'(cfg_reg);
    assign ch8    = {4'd0, channel};
    assign chi    = ch8[CH_W-1:0];
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign last   = ((8'(idx_reg) + 8'd1) == n8);

    assign pin_ext          = PIN_EXT_W'(pin_reg);
    assign pin_levels       = pin_ext[PIN_W-1:0];
    assign done             = done_reg;
    assign status           = status_reg;
    assign assigned_channel = assigned_reg;
    assign level            = level_reg;

    mob_serve u_serve (
        .rec        (rd_reg),
        .now_ms     (now_reg),
        .allocated  (alloc_reg[idx_reg]),
        .active_low (al_reg[idx_reg]),
        .pin        (pin_reg[idx_reg]),
        .mode       (mode_reg[idx_reg]),
        .result     (srv)
    );

    // blink record memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= 5'd16;
            now_reg      <= '0;
            idx_reg      <= '0;
            alloc_reg    <= '0;
            al_reg       <= '0;
            pin_reg      <= '0;
            done_reg     <= 1'b0;
            status_reg   <= STATUS_OK;
            assigned_reg <= '0;
            level_reg    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                mode_reg[i] <= MODE_STEADY;
            end
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            now_reg      <= now_next;
            idx_reg      <= idx_next;
            alloc_reg    <= alloc_next;
            al_reg       <= al_next;
            pin_reg      <= pin_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            assigned_reg <= assigned_next;
            level_reg    <= level_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                mode_reg[i] <= mode_next[i];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd_t'(cmd) == CMD_TICK) && (n8 != 8'd0))
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                state_next = last ? ST_IDLE : ST_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic            found;
        logic [CH_W-1:0] free_idx;

        found         = 1'b0;
        free_idx      = '0;
        now_next      = now_reg;
        idx_next      = idx_reg;
        alloc_next    = alloc_reg;
        al_next       = al_reg;
        pin_next      = pin_reg;
        mode_next     = mode_reg;
        done_next     = 1'b0;
        status_next   = STATUS_OK;
        assigned_next = '0;
        level_next    = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = chi;
        mem_wdata     = '{on_dur: on_ms, off_dur: off_ms,
                          deadline: now_reg + 32'(on_ms),
                          done_cnt: 16'd0, wanted_cnt: blink_count};

        for (int i = 0; i < CHANNELS; i++)
        begin
            if (!found && (8'(i) < n8) && !alloc_reg[i])
            begin
                found    = 1'b1;
                free_idx = CH_W'(i);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_TICK:
                        begin
                            now_next  = now_reg + 32'd1;
                            idx_next  = '0;
                            done_next = (n8 == 8'd0);
                        end
                        CMD_ALLOC:
                        begin
                            done_next = 1'b1;
                            if (found)
                            begin
                                alloc_next[free_idx] = 1'b1;
                                al_next[free_idx]    = polarity;
                                assigned_next        = 4'(free_idx);
                            end
                            else
                            begin
                                status_next = STATUS_NO_FREE;
                            end
                        end
                        CMD_HIGH, CMD_LOW, CMD_TOGGLE, CMD_ON, CMD_OFF,
                        CMD_RD_LVL, CMD_RD_ACT, CMD_BLINK, CMD_BLINK_N:
                        begin
                            done_next = 1'b1;
                            if (ch8 >= n8)
                            begin
                                status_next = STATUS_BAD_CHANNEL;
                            end
                            else if (!alloc_reg[chi])
                            begin
                                status_next = STATUS_NOT_ALLOCATED;
                            end
                            else
                            begin
                                unique case (cmd_t'(cmd))
                                    CMD_HIGH:
                                    begin
                                        mode_next[chi] = MODE_STEADY;
                                        pin_next[chi]  = 1'b1;
                                    end
                                    CMD_LOW:
                                    begin
                                        mode_next[chi] = MODE_STEADY;
                                        pin_next[chi]  = 1'b0;
                                    end
                                    CMD_TOGGLE:
                                    begin
                                        mode_next[chi] = MODE_STEADY;
                                        pin_next[chi]  = ~pin_reg[chi];
                                    end
                                    CMD_ON:
                                    begin
                                        mode_next[chi] = MODE_STEADY;
                                        pin_next[chi]  = ~al_reg[chi];
                                    end
                                    CMD_OFF:
                                    begin
                                        mode_next[chi] = MODE_STEADY;
                                        pin_next[chi]  = al_reg[chi];
                                    end
                                    CMD_RD_LVL:
                                    begin
                                        level_next = pin_reg[chi];
                                    end
                                    CMD_RD_ACT:
                                    begin
                                        level_next = pin_reg[chi] ^ al_reg[chi];
                                    end
                                    CMD_BLINK:
                                    begin
                                        mode_next[chi] = MODE_BLINK;
                                        mem_we         = 1'b1;
                                    end
                                    default:
                                    begin
                                        mode_next[chi] = MODE_BLINK_N;
                                        mem_we         = 1'b1;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                mem_re = 1'b1;
            end
            ST_WR:
            begin
                mem_waddr = idx_reg;
                mem_wdata = srv.rec;
                if (srv.due)
                begin
                    pin_next[idx_reg]  = srv.pin;
                    mode_next[idx_reg] = srv.mode;
                    mem_we             = 1'b1;
                end
                idx_next  = idx_reg + CH_W'(1);
                done_next = last;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ tb/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mob_pkg::*;

    localparam logic [3:0] CMD_UNUSED_MAX = 4'd15;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 200;

    typedef struct {
        status_t     status;
        logic [3:0]  assigned;
        logic        level;
        logic [15:0] pins;
    } blink_result_t;

    typedef struct {
        logic [3:0]    cmd;
        logic [3:0]    channel;
        logic          polarity;
        logic [15:0]   on_t;
        logic [15:0]   off_t;
        logic [15:0]   count;
        logic          typed;
        blink_result_t exp;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = 5'd0;
    logic [3:0]  cmd = 4'd0;
    logic [3:0]  channel = 4'd0;
    logic        polarity = 1'b0;
    logic [15:0] on_ms = 16'd0;
    logic [15:0] off_ms = 16'd0;
    logic [15:0] blink_count = 16'd0;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  assigned_channel;
    logic        level;
    logic [15:0] pin_levels;

    // channel state as the blinker should hold it
    logic        chan_allocated [CHANNELS];
    logic        chan_active_low [CHANNELS];
    mode_t       chan_mode [CHANNELS];
    logic        chan_pin [CHANNELS];
    logic [15:0] chan_on [CHANNELS];
    logic [15:0] chan_off [CHANNELS];
    logic [31:0] chan_deadline [CHANNELS];
    logic [15:0] chan_done [CHANNELS];
    logic [15:0] chan_wanted [CHANNELS];
    logic [31:0] model_now;
    logic [4:0]  channels_cfg;

    blink_result_t pending_results[$];
    stim_row_t     directed_rows[$];

    int mismatch_count = 0;
    int results_checked = 0;
    int commands_sent = 0;
    int ticks_sent = 0;
    int blink_toggles = 0;
    int settings_used = 0;

    multichannel_output_blinker dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .channel          (channel),
        .polarity         (polarity),
        .on_ms            (on_ms),
        .off_ms           (off_ms),
        .blink_count      (blink_count),
        .done             (done),
        .status           (status),
        .assigned_channel (assigned_channel),
        .level            (level),
        .pin_levels       (pin_levels)
    );

    always #4 clk = ~clk;

    task automatic predict_command(input stim_row_t it, output blink_result_t res);
        int managed;
        int ch;
        logic [31:0] lag;
        managed = (channels_cfg > CHANNELS) ? CHANNELS : int'(channels_cfg);
        ch = int'(it.channel);
        res = '{STATUS_OK, 4'd0, 1'b0, 16'h0000};
        if (it.cmd == CMD_TICK)
        begin
            model_now = model_now + 32'd1;
            for (int i = 0; i < managed; i++)
            begin
                lag = model_now - chan_deadline[i];
                if (chan_allocated[i] && chan_mode[i] != MODE_STEADY && !lag[31])
                begin
                    if (chan_pin[i] ^ chan_active_low[i])
                    begin
                        chan_deadline[i] = model_now + 32'(chan_off[i]);
                        if (chan_mode[i] == MODE_BLINK_N)
                        begin
                            chan_done[i] = chan_done[i] + 16'd1;
                            if (chan_done[i] >= chan_wanted[i])
                                chan_mode[i] = MODE_STEADY;
                        end
                    end
                    else
                    begin
                        chan_deadline[i] = model_now + 32'(chan_on[i]);
                    end
                    chan_pin[i] = ~chan_pin[i];
                    blink_toggles++;
                end
            end
        end
        else if (it.cmd == CMD_ALLOC)
        begin
            res.status = STATUS_NO_FREE;
            for (int i = 0; i < managed; i++)
            begin
                if (!chan_allocated[i])
                begin
                    chan_allocated[i] = 1'b1;
                    chan_active_low[i] = it.polarity;
                    res.assigned = 4'(i);
                    res.status = STATUS_OK;
                    break;
                end
            end
        end
        else if (it.cmd <= CMD_BLINK_N)
        begin
            if (ch >= managed)
                res.status = STATUS_BAD_CHANNEL;
            else if (!chan_allocated[ch])
                res.status = STATUS_NOT_ALLOCATED;
            else
            begin
                case (it.cmd)
                    CMD_HIGH:
                    begin
                        chan_mode[ch] = MODE_STEADY;
                        chan_pin[ch] = 1'b1;
                    end
                    CMD_LOW:
                    begin
                        chan_mode[ch] = MODE_STEADY;
                        chan_pin[ch] = 1'b0;
                    end
                    CMD_TOGGLE:
                    begin
                        chan_mode[ch] = MODE_STEADY;
                        chan_pin[ch] = ~chan_pin[ch];
                    end
                    CMD_ON:
                    begin
                        chan_mode[ch] = MODE_STEADY;
                        chan_pin[ch] = ~chan_active_low[ch];
                    end
                    CMD_OFF:
                    begin
                        chan_mode[ch] = MODE_STEADY;
                        chan_pin[ch] = chan_active_low[ch];
                    end
                    CMD_RD_LVL:
                        res.level = chan_pin[ch];
                    CMD_RD_ACT:
                        res.level = chan_pin[ch] ^ chan_active_low[ch];
                    default:
                    begin
                        chan_on[ch] = it.on_t;
                        chan_off[ch] = it.off_t;
                        chan_deadline[ch] = model_now + 32'(it.on_t);
                        if (it.cmd == CMD_BLINK)
                            chan_mode[ch] = MODE_BLINK;
                        else
                        begin
                            chan_mode[ch] = MODE_BLINK_N;
                            chan_wanted[ch] = it.count;
                            chan_done[ch] = 16'd0;
                        end
                    end
                endcase
            end
        end
        for (int i = 0; i < CHANNELS; i++)
            res.pins[i] = chan_pin[i];
    endtask

    function automatic stim_row_t cmd_row(input logic [3:0] c, input logic [3:0] ch,
                                          input logic pol, input logic [15:0] on_t,
                                          input logic [15:0] off_t, input logic [15:0] cnt,
                                          input logic typed, input status_t st,
                                          input logic [3:0] asg, input logic lvl,
                                          input logic [15:0] pins);
        stim_row_t r;
        r.cmd = c;
        r.channel = ch;
        r.polarity = pol;
        r.on_t = on_t;
        r.off_t = off_t;
        r.count = cnt;
        r.typed = typed;
        r.exp = '{st, asg, lvl, pins};
        return r;
    endfunction

    function automatic stim_row_t random_command(input int managed);
        stim_row_t it;
        int pick;
        it.typed = 1'b0;
        it.exp = '{STATUS_OK, 4'd0, 1'b0, 16'h0000};
        it.polarity = 1'($urandom_range(0, 1));
        it.on_t = 16'($urandom_range(0, 65535));
        it.off_t = 16'($urandom_range(0, 65535));
        it.count = 16'($urandom_range(0, 65535));
        it.channel = 4'($urandom_range(0, 15));
        if (managed > 0 && $urandom_range(0, 9) != 0)
            it.channel = 4'($urandom_range(0, managed - 1));
        pick = $urandom_range(0, 99);
        if (pick < 38)
            it.cmd = CMD_TICK;
        else if (pick < 44)
            it.cmd = CMD_ALLOC;
        else if (pick < 60)
        begin
            it.cmd = (pick < 52) ? CMD_BLINK : CMD_BLINK_N;
            // short periods so that ticks keep the channels toggling
            if ($urandom_range(0, 19) != 0)
            begin
                it.on_t = 16'($urandom_range(0, 4));
                it.off_t = 16'($urandom_range(0, 4));
            end
            if ($urandom_range(0, 9) != 0)
                it.count = 16'($urandom_range(0, 4));
        end
        else if (pick < 78)
            it.cmd = 4'($urandom_range(int'(CMD_HIGH), int'(CMD_OFF)));
        else if (pick < 92)
            it.cmd = 4'($urandom_range(int'(CMD_RD_LVL), int'(CMD_RD_ACT)));
        else if (pick < 96)
            it.cmd = 4'($urandom_range(int'(CMD_BLINK_N) + 1, int'(CMD_UNUSED_MAX)));
        else
        begin
            it.cmd = 4'($urandom_range(0, int'(CMD_UNUSED_MAX)));
            it.channel = 4'($urandom_range(0, 15));
        end
        return it;
    endfunction

    task automatic send_command(input stim_row_t it, input int gap_pct);
        blink_result_t predicted;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= it.cmd;
        channel <= it.channel;
        polarity <= it.polarity;
        on_ms <= it.on_t;
        off_ms <= it.off_t;
        blink_count <= it.count;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_command(it, predicted);
        pending_results.push_back(it.typed ? it.exp : predicted);
        commands_sent++;
        if (it.cmd == CMD_TICK)
            ticks_sent++;
    endtask

    task automatic write_channels_in_use(input logic [4:0] value);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        channels_cfg = value;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        blink_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d pin_levels %h", status, pin_levels);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatch_count++;
                end
                if (assigned_channel !== want.assigned)
                begin
                    $error("assigned_channel: expected %0d, actual %0d",
                           want.assigned, assigned_channel);
                    mismatch_count++;
                end
                if (level !== want.level)
                begin
                    $error("level: expected %0d, actual %0d", want.level, level);
                    mismatch_count++;
                end
                if (pin_levels !== want.pins)
                begin
                    $error("pin_levels: expected %h, actual %h", want.pins, pin_levels);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int unsigned phase_cfg [PHASES] = '{16, 31, 0, 5, 17, 9, 1};
        int gap_rate [3] = '{0, 47, 21};
        int managed;

        for (int i = 0; i < CHANNELS; i++)
        begin
            chan_allocated[i] = 1'b0;
            chan_active_low[i] = 1'b0;
            chan_mode[i] = MODE_STEADY;
            chan_pin[i] = 1'b0;
            chan_on[i] = 16'd0;
            chan_off[i] = 16'd0;
            chan_deadline[i] = 32'd0;
            chan_done[i] = 16'd0;
            chan_wanted[i] = 16'd0;
        end
        model_now = 32'd0;
        channels_cfg = 5'd16;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two managed channels so the full and out-of-range cases come quickly
        write_channels_in_use(5'd2);

        directed_rows.push_back(cmd_row(CMD_TICK, 0, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_HIGH, 0, 0, 0, 0, 0,
                                        1, STATUS_NOT_ALLOCATED, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_RD_LVL, 2, 0, 0, 0, 0,
                                        1, STATUS_BAD_CHANNEL, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_UNUSED_MAX, 15, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                        1, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_ALLOC, 0, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_ALLOC, 0, 1, 0, 0, 0,
                                        1, STATUS_OK, 1, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_ALLOC, 0, 1, 0, 0, 0,
                                        1, STATUS_NO_FREE, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_ON, 0, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0001));
        directed_rows.push_back(cmd_row(CMD_ON, 1, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0001));
        directed_rows.push_back(cmd_row(CMD_OFF, 1, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0003));
        directed_rows.push_back(cmd_row(CMD_RD_ACT, 1, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0003));
        directed_rows.push_back(cmd_row(CMD_RD_LVL, 1, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 1, 16'h0003));
        directed_rows.push_back(cmd_row(CMD_TOGGLE, 0, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0002));
        directed_rows.push_back(cmd_row(CMD_LOW, 1, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_HIGH, 0, 0, 0, 0, 0,
                                        1, STATUS_OK, 0, 0, 16'h0001));
        // blinking start, zero count, counted blink and longest periods
        directed_rows.push_back(cmd_row(CMD_BLINK, 0, 0, 0, 0, 0,
                                        0, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_TICK, 0, 0, 0, 0, 0,
                                        0, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_BLINK_N, 1, 0, 1, 1, 0,
                                        0, STATUS_OK, 0, 0, 16'h0000));
        for (int i = 0; i < 4; i++)
            directed_rows.push_back(cmd_row(CMD_TICK, 0, 0, 0, 0, 0,
                                            0, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_BLINK_N, 0, 0, 2, 1, 2,
                                        0, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_TICK, 0, 0, 0, 0, 0,
                                        0, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_TICK, 0, 0, 0, 0, 0,
                                        0, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_BLINK, 1, 0, 16'hFFFF, 16'hFFFF, 0,
                                        0, STATUS_OK, 0, 0, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_RD_ACT, 0, 0, 0, 0, 0,
                                        0, STATUS_OK, 0, 0, 16'h0000));

        foreach (directed_rows[i])
            send_command(directed_rows[i], 21);

        for (int p = 0; p < PHASES; p++)
        begin
            write_channels_in_use(5'(phase_cfg[p]));
            managed = (channels_cfg > CHANNELS) ? CHANNELS : int'(channels_cfg);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_command(random_command(managed), gap_rate[p % 3]);
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("checked %0d results from %0d commands, %0d of them ticks, %0d blink toggles",
                 results_checked, commands_sent, ticks_sent, blink_toggles);
        $display("channel count written %0d times, from 0 to 31, sender gaps of 0 to 47 percent",
                 settings_used);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
